// ===== hw/rtl/frame_descriptor_ring_assert.svh =====
// assertion macros used by the descriptor ring controller
`ifndef FRAME_DESCRIPTOR_RING_ASSERT_SVH
`define FRAME_DESCRIPTOR_RING_ASSERT_SVH

// same-cycle implication, checked at every rising edge outside reset
`define FDR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define FDR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/fdr_pkg.sv =====
package fdr_pkg;

   // sizes
   localparam int MAX_SLOTS        = 16;
   localparam int MAX_BUFFER_BYTES = 4096;
   localparam int SLOT_W           = $clog2(MAX_SLOTS);
   localparam int OFF_W            = $clog2(MAX_BUFFER_BYTES);
   localparam int LEN_W            = 13;
   localparam int ADDR_W           = 32;
   localparam int SCNT_W           = 5;
   localparam int OP_W             = 2;
   localparam int STATUS_W         = 2;
   localparam int CSR_IDX_W        = 2;

   // operation codes
   localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
   localparam logic [OP_W-1:0] OP_POP     = 2'd1;
   localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BUFFER_SIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_MAX    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_COUNT   = 2'd3;

   // descriptor memory access
   typedef struct packed {
      logic              rd_en;
      logic [SLOT_W-1:0] rd_addr;
      logic              start_we;
      logic [SLOT_W-1:0] start_addr;
      logic [OFF_W-1:0]  start_data;
      logic              end_we;
      logic [SLOT_W-1:0] end_addr;
      logic [OFF_W-1:0]  end_data;
   } mem_req_type;

   typedef struct packed {
      logic [OFF_W-1:0] start_off;
      logic [OFF_W-1:0] end_off;
   } mem_rsp_type;

endpackage

// ===== hw/rtl/fdr_desc_mem.sv =====
module fdr_desc_mem (
   input  logic                 clock,
   input  logic                 reset,
   input  fdr_pkg::mem_req_type mem_req,
   output fdr_pkg::mem_rsp_type mem_rsp
);
   import fdr_pkg::*;

   logic [OFF_W-1:0] start_mem [MAX_SLOTS];
   logic [OFF_W-1:0] end_mem   [MAX_SLOTS];
   logic [OFF_W-1:0] start_rd_ff;
   logic [OFF_W-1:0] end_rd_ff;
   logic             blank0_ff;
   logic             s0_written_ff;
   logic             s0_written_in;

   // start offsets, one write and one registered read
   always_ff @(posedge clock) begin
      if (mem_req.start_we) begin
         start_mem[mem_req.start_addr] <= mem_req.start_data;
      end
      if (mem_req.rd_en) begin
         start_rd_ff <= start_mem[mem_req.rd_addr];
         blank0_ff   <= (mem_req.rd_addr == '0) && !s0_written_ff;
      end
   end

   // end offsets
   always_ff @(posedge clock) begin
      if (mem_req.end_we) begin
         end_mem[mem_req.end_addr] <= mem_req.end_data;
      end
      if (mem_req.rd_en) begin
         end_rd_ff <= end_mem[mem_req.rd_addr];
      end
   end

   // slot zero start reads as zero until first written
   assign s0_written_in = s0_written_ff || (mem_req.start_we && (mem_req.start_addr == '0));

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_written_ff <= 1'b0;
      end else begin
         s0_written_ff <= s0_written_in;
      end
   end

   assign mem_rsp.start_off = blank0_ff ? '0 : start_rd_ff;
   assign mem_rsp.end_off   = end_rd_ff;

endmodule

// ===== hw/rtl/fdr_ctrl.sv =====
`include "frame_descriptor_ring_assert.svh"

module fdr_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [fdr_pkg::OP_W-1:0]      req_operation,
   input  logic [fdr_pkg::LEN_W-1:0]     req_frame_length,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fdr_pkg::STATUS_W-1:0]  rsp_status,
   output logic [fdr_pkg::ADDR_W-1:0]    rsp_frame_address,
   output logic [fdr_pkg::LEN_W-1:0]     rsp_popped_length,
   output logic [fdr_pkg::ADDR_W-1:0]    rsp_next_write_address,
   input  logic [fdr_pkg::ADDR_W-1:0]    cfg_base_address,
   input  logic [fdr_pkg::LEN_W-1:0]     cfg_buffer_size,
   input  logic [fdr_pkg::LEN_W-1:0]     cfg_frame_max,
   input  logic [fdr_pkg::SCNT_W-1:0]    cfg_slot_count,
   output fdr_pkg::mem_req_type          mem_req,
   input  fdr_pkg::mem_rsp_type          mem_rsp
);
   import fdr_pkg::*;

   localparam int CNT_W = SLOT_W + 1;
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic                state_ff, state_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [SLOT_W-1:0]   write_slot_ff, write_slot_in;
   logic [SLOT_W-1:0]   read_slot_ff, read_slot_in;
   logic [LEN_W-1:0]    fill_ff, fill_in;
   logic [OFF_W-1:0]    wr_start_ff, wr_start_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ADDR_W-1:0]   faddr_ff, faddr_in;
   logic [LEN_W-1:0]    plen_ff, plen_in;
   logic [ADDR_W-1:0]   nwa_ff, nwa_in;

   logic                accept;
   logic                done;
   logic [LEN_W-1:0]    size_eff;
   logic [LEN_W-1:0]    fm_eff;
   logic [CNT_W-1:0]    slot_last;
   logic [LEN_W-1:0]    room_cur;
   logic [LEN_W-1:0]    new_fill;
   logic [LEN_W-1:0]    room_new;
   logic                reject;
   logic                wrap;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s,
                                                   input logic [CNT_W-1:0]  last);
      logic [CNT_W-1:0] n;
      n = {1'b0, s} + CNT_W'(1);
      return (n >= last) ? '0 : n[SLOT_W-1:0];
   endfunction

   // handshakes
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign done      = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   // clamped configuration
   always_comb begin
      size_eff = (cfg_buffer_size == '0) ? LEN_W'(1) :
                 (cfg_buffer_size > LEN_W'(MAX_BUFFER_BYTES)) ? LEN_W'(MAX_BUFFER_BYTES) :
                 cfg_buffer_size;
      fm_eff   = (cfg_frame_max == '0) ? LEN_W'(1) : cfg_frame_max;
      if (cfg_slot_count < SCNT_W'(2)) begin
         slot_last = CNT_W'(1);
      end else if (cfg_slot_count > SCNT_W'(MAX_SLOTS)) begin
         slot_last = CNT_W'(MAX_SLOTS - 1);
      end else begin
         slot_last = CNT_W'(cfg_slot_count) - CNT_W'(1);
      end
   end

   // push arithmetic
   always_comb begin
      room_cur = size_eff - fill_ff;
      reject   = (len_ff == '0) || (fill_ff > size_eff) || (len_ff > room_cur);
      new_fill = fill_ff + len_ff;
      room_new = size_eff - new_fill;
      wrap     = (room_new < fm_eff);
   end

   // item execution, memory writes and result
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      len_in        = len_ff;
      write_slot_in = write_slot_ff;
      read_slot_in  = read_slot_ff;
      fill_in       = fill_ff;
      wr_start_in   = wr_start_ff;
      status_in     = status_ff;
      faddr_in      = faddr_ff;
      plen_in       = plen_ff;
      nwa_in        = nwa_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      mem_req            = '0;
      mem_req.rd_en      = accept;
      mem_req.rd_addr    = read_slot_ff;

      if (accept) begin
         op_in    = req_operation;
         len_in   = req_frame_length;
         state_in = ST_EXEC;
      end

      if (done) begin
         state_in     = ST_IDLE;
         rsp_valid_in = 1'b1;
         status_in    = ST_OK;
         faddr_in     = '0;
         plen_in      = '0;
         unique case (op_ff)
            OP_PUSH: begin
               if (reject) begin
                  status_in = ST_OVERFLOW;
               end else begin
                  mem_req.end_we     = 1'b1;
                  mem_req.end_addr   = write_slot_ff;
                  mem_req.end_data   = OFF_W'(new_fill - LEN_W'(1));
                  write_slot_in      = next_slot(write_slot_ff, slot_last);
                  mem_req.start_we   = 1'b1;
                  mem_req.start_addr = write_slot_in;
                  mem_req.start_data = wrap ? '0 : new_fill[OFF_W-1:0];
                  fill_in            = wrap ? '0 : new_fill;
                  wr_start_in        = mem_req.start_data;
               end
            end
            OP_POP: begin
               if (read_slot_ff != write_slot_ff) begin
                  faddr_in     = cfg_base_address + ADDR_W'(mem_rsp.start_off);
                  plen_in      = LEN_W'(mem_rsp.end_off) - LEN_W'(mem_rsp.start_off)
                                 + LEN_W'(1);
                  read_slot_in = next_slot(read_slot_ff, slot_last);
               end else begin
                  status_in = ST_EMPTY;
               end
            end
            OP_RESTART: begin
               write_slot_in      = '0;
               read_slot_in       = '0;
               fill_in            = '0;
               wr_start_in        = '0;
               mem_req.start_we   = 1'b1;
               mem_req.start_addr = '0;
               mem_req.start_data = '0;
            end
            default: begin
            end
         endcase
         nwa_in = cfg_base_address + ADDR_W'(wr_start_in);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         write_slot_ff <= '0;
         read_slot_ff  <= '0;
         fill_ff       <= '0;
         wr_start_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         write_slot_ff <= write_slot_in;
         read_slot_ff  <= read_slot_in;
         fill_ff       <= fill_in;
         wr_start_ff   <= wr_start_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      len_ff    <= len_in;
      status_ff <= status_in;
      faddr_ff  <= faddr_in;
      plen_ff   <= plen_in;
      nwa_ff    <= nwa_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = status_ff;
   assign rsp_frame_address      = faddr_ff;
   assign rsp_popped_length      = plen_ff;
   assign rsp_next_write_address = nwa_ff;

   // checks
   `FDR_ASSERT_NEXT(a_accept_to_exec, clock, reset, accept, state_ff == ST_EXEC, "accepted item did not enter execution")
   `FDR_ASSERT_NOW(a_no_write_on_accept, clock, reset, mem_req.start_we || mem_req.end_we, !accept, "descriptor write overlaps an accepted transfer")
   `FDR_ASSERT_NEXT(a_done_gives_result, clock, reset, done, rsp_valid_ff && (state_ff == ST_IDLE), "completed item left no result")
   `FDR_ASSERT_NOW(a_fill_in_range, clock, reset, 1'b1, fill_ff <= LEN_W'(MAX_BUFFER_BYTES), "fill count beyond buffer limit")

endmodule

// ===== hw/rtl/frame_descriptor_ring.sv =====
// channel   direction  transfer when           payload
// req_      in         req_valid & req_ready   req_operation, req_frame_length
// rsp_      out        rsp_valid & rsp_ready   rsp_status, rsp_frame_address,
//                                              rsp_popped_length, rsp_next_write_address
// csr_      in         csr_valid & csr_ready   csr_index, csr_data (always ready)
//
// every item first reads the descriptor memory when it is accepted, then executes
// the registered read of the descriptor memory sets that order
// a new item is taken while the previous result still waits in the output register
// a stalled result holds execution of the following item until it is taken
// synchronous reset clears pointers and fill count, no memory clearing pass is run
module frame_descriptor_ring (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [fdr_pkg::OP_W-1:0]         req_operation,
   input  logic [fdr_pkg::LEN_W-1:0]        req_frame_length,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [fdr_pkg::STATUS_W-1:0]     rsp_status,
   output logic [fdr_pkg::ADDR_W-1:0]       rsp_frame_address,
   output logic [fdr_pkg::LEN_W-1:0]        rsp_popped_length,
   output logic [fdr_pkg::ADDR_W-1:0]       rsp_next_write_address,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fdr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fdr_pkg::ADDR_W-1:0]       csr_data
);
   import fdr_pkg::*;

   logic [ADDR_W-1:0] base_ff, base_in;
   logic [LEN_W-1:0]  size_ff, size_in;
   logic [LEN_W-1:0]  fmax_ff, fmax_in;
   logic [SCNT_W-1:0] scnt_ff, scnt_in;
   mem_req_type       mem_req;
   mem_rsp_type       mem_rsp;

   assign csr_ready = 1'b1;

   // configuration register writes
   always_comb begin
      base_in = base_ff;
      size_in = size_ff;
      fmax_in = fmax_ff;
      scnt_in = scnt_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BASE_ADDRESS: base_in = csr_data;
            CSR_BUFFER_SIZE:  size_in = csr_data[LEN_W-1:0];
            CSR_FRAME_MAX:    fmax_in = csr_data[LEN_W-1:0];
            CSR_SLOT_COUNT:   scnt_in = csr_data[SCNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         size_ff <= LEN_W'(4096);
         fmax_ff <= LEN_W'(256);
         scnt_ff <= SCNT_W'(16);
      end else begin
         base_ff <= base_in;
         size_ff <= size_in;
         fmax_ff <= fmax_in;
         scnt_ff <= scnt_in;
      end
   end

   // sequencer and pointers
   fdr_ctrl u_ctrl (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_operation          (req_operation),
      .req_frame_length       (req_frame_length),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_status             (rsp_status),
      .rsp_frame_address      (rsp_frame_address),
      .rsp_popped_length      (rsp_popped_length),
      .rsp_next_write_address (rsp_next_write_address),
      .cfg_base_address       (base_ff),
      .cfg_buffer_size        (size_ff),
      .cfg_frame_max          (fmax_ff),
      .cfg_slot_count         (scnt_ff),
      .mem_req                (mem_req),
      .mem_rsp                (mem_rsp)
   );

   // descriptor storage
   fdr_desc_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .mem_rsp (mem_rsp)
   );

endmodule
